### rtl/xcr_pkg.sv
// Package for the XMODEM checksum receiver: request and result types,
// protocol characters, framing constants and register addresses.
// Depends on nothing; every rtl file imports it.
package xcr_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int BLOCK_BYTES = 128;
    localparam int FIELD_W     = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_RESULTS = 3;

    // framing: header, block number, complement, then data, then checksum
    localparam logic [7:0] POS_HEADER = 8'd0;
    localparam logic [7:0] POS_BLKNUM = 8'd1;
    localparam logic [7:0] POS_CMPL   = 8'd2;
    localparam logic [7:0] POS_DATA   = 8'd3;
    localparam logic [7:0] POS_SUM    = 8'(3 + BLOCK_BYTES);

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;

    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_BYTE    = 2'd1;
    localparam logic [1:0] ACT_TIMEOUT = 2'd2;

    localparam logic [1:0] KIND_REPLY  = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ABORT   = 2'd1;
    localparam logic [1:0] ST_BADSUM  = 2'd2;
    localparam logic [1:0] ST_RETRIES = 2'd3;

    localparam logic [1:0] SP_MUST_NAK = 2'd0;
    localparam logic [1:0] SP_SENT_NAK = 2'd1;
    localparam logic [1:0] SP_PAST     = 2'd2;

    localparam logic [7:0] RETRY_RESET = 8'd20;
    localparam logic [7:0] BLOCK_FIRST = 8'd1;

    localparam logic REG_ONE_NAK = 1'b0;
    localparam logic REG_RETRY   = 1'b1;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rx_byte;
    } t_request;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         tx_byte;
        logic [FIELD_W-1:0] write_offset;
        logic [7:0]         write_data;
        logic [1:0]         status;
        logic [FIELD_W-1:0] length;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [1:0]                   count;
        t_result [MAX_RESULTS-1:0]    res;
    } t_push;

    typedef struct packed {
        logic       one_nak_mode;
        logic [7:0] retry_limit;
    } t_cfg;

    function automatic t_result mk_reply(input logic [7:0] ch);
        t_result r;
        r         = '0;
        r.kind    = KIND_REPLY;
        r.tx_byte = ch;
        return r;
    endfunction

    function automatic t_result mk_write(input logic [OFFSET_BITS-1:0] addr,
                                         input logic [7:0] data);
        t_result r;
        r              = '0;
        r.kind         = KIND_WRITE;
        r.write_offset = FIELD_W'(addr);
        r.write_data   = data;
        return r;
    endfunction

    function automatic t_result mk_finish(input logic [1:0] st,
                                          input logic [OFFSET_BITS-1:0] len);
        t_result r;
        r        = '0;
        r.kind   = KIND_FINISH;
        r.status = st;
        r.length = FIELD_W'(len);
        return r;
    endfunction

endpackage

### rtl/xcr_regs.sv
// Configuration registers behind the APB-style port.
// Depends on xcr_pkg for t_cfg and register codes.
module xcr_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output xcr_pkg::t_cfg o_cfg
);
    import xcr_pkg::*;

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    // word-aligned decode: byte lane bits are not part of the address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.one_nak_mode <= 1'b0;
            r_cfg.retry_limit  <= RETRY_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_ONE_NAK: r_cfg.one_nak_mode <= pwdata[0];
                REG_RETRY:   r_cfg.retry_limit  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_ONE_NAK: prdata = {31'd0, r_cfg.one_nak_mode};
            REG_RETRY:   prdata = {24'd0, r_cfg.retry_limit};
            default:     prdata = '0;
        endcase
    end

endmodule

### rtl/xcr_core.sv
// Framing state and reply logic: one request in, up to three results out.
// Depends on xcr_pkg for types, characters and framing constants.
module xcr_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  xcr_pkg::t_request i_req,
    input  xcr_pkg::t_cfg     i_cfg,
    output xcr_pkg::t_push    o_push
);
    import xcr_pkg::*;

    logic                   r_running,  n_running;
    logic [1:0]             r_phase,    n_phase;
    logic [7:0]             r_pos,      n_pos;
    logic [7:0]             r_blknum,   n_blknum;
    logic [7:0]             r_sum,      n_sum;
    logic [7:0]             r_expect,   n_expect;
    logic [7:0]             r_retries,  n_retries;
    logic [OFFSET_BITS-1:0] r_offset,   n_offset;

    always_comb begin
        t_result [MAX_RESULTS-1:0] res;
        logic [1:0] cnt;
        logic       fin;
        logic [7:0] dec;

        n_running = r_running;
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_blknum  = r_blknum;
        n_sum     = r_sum;
        n_expect  = r_expect;
        n_retries = r_retries;
        n_offset  = r_offset;
        res       = '0;
        cnt       = 2'd0;
        fin       = 1'b0;
        dec       = r_retries - 8'd1;

        if (i_accept) begin
            case (i_req.action)
                ACT_START: begin
                    n_running = 1'b1;
                    n_phase   = SP_MUST_NAK;
                    n_pos     = POS_HEADER;
                    n_blknum  = 8'd0;
                    n_sum     = 8'd0;
                    n_expect  = BLOCK_FIRST;
                    n_retries = i_cfg.retry_limit;
                    n_offset  = '0;
                end
                ACT_TIMEOUT: begin
                    if (r_running) begin
                        if (r_phase == SP_MUST_NAK || !i_cfg.one_nak_mode) begin
                            res[cnt] = mk_reply(CH_NAK);
                            cnt      = cnt + 2'd1;
                        end
                        if (r_phase != SP_PAST) begin
                            n_phase = SP_SENT_NAK;
                        end else begin
                            // drop the partial record, spend one retry
                            n_pos     = POS_HEADER;
                            n_sum     = 8'd0;
                            res[cnt]  = mk_reply(CH_NAK);
                            cnt       = cnt + 2'd1;
                            n_retries = dec;
                            if (dec == 8'd0) begin
                                res[cnt] = mk_finish(ST_RETRIES, '0);
                                cnt      = cnt + 2'd1;
                                fin      = 1'b1;
                            end
                        end
                    end
                end
                ACT_BYTE: begin
                    if (r_running) begin
                        n_phase = SP_PAST;
                        if (r_pos == POS_HEADER) begin
                            if (i_req.rx_byte == CH_SOH) begin
                                n_pos = POS_BLKNUM;
                                n_sum = 8'd0;
                            end else begin
                                res[cnt] = mk_reply(CH_ACK);
                                cnt      = cnt + 2'd1;
                                if (i_req.rx_byte == CH_EOT) begin
                                    res[cnt] = mk_finish(ST_OK, r_offset);
                                end else begin
                                    res[cnt] = mk_finish(ST_ABORT, '0);
                                end
                                cnt = cnt + 2'd1;
                                fin = 1'b1;
                            end
                        end else if (r_pos == POS_BLKNUM) begin
                            n_blknum = i_req.rx_byte;
                            n_pos    = POS_CMPL;
                        end else if (r_pos == POS_CMPL) begin
                            n_pos = POS_DATA;
                        end else if (r_pos < POS_SUM) begin
                            res[cnt] = mk_write(r_offset + OFFSET_BITS'(r_pos - POS_DATA),
                                                i_req.rx_byte);
                            cnt      = cnt + 2'd1;
                            n_sum    = r_sum + i_req.rx_byte;
                            n_pos    = r_pos + 8'd1;
                        end else begin
                            n_pos = POS_HEADER;
                            n_sum = 8'd0;
                            if (r_sum != i_req.rx_byte) begin
                                res[cnt] = mk_reply(CH_NAK);
                                cnt      = cnt + 2'd1;
                                res[cnt] = mk_finish(ST_BADSUM, '0);
                                cnt      = cnt + 2'd1;
                                fin      = 1'b1;
                            end else if (r_blknum == r_expect) begin
                                n_retries = i_cfg.retry_limit;
                                n_expect  = r_expect + 8'd1;
                                n_offset  = r_offset + OFFSET_BITS'(BLOCK_BYTES);
                                res[cnt]  = mk_reply(CH_ACK);
                                cnt       = cnt + 2'd1;
                            end else begin
                                res[cnt]  = mk_reply(CH_NAK);
                                cnt       = cnt + 2'd1;
                                n_retries = dec;
                                if (dec == 8'd0) begin
                                    res[cnt] = mk_finish(ST_RETRIES, '0);
                                    cnt      = cnt + 2'd1;
                                    fin      = 1'b1;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        if (fin) begin
            n_running = 1'b0;
            n_pos     = POS_HEADER;
            n_sum     = 8'd0;
        end
        if (cnt != 2'd0) begin
            res[cnt - 2'd1].last = 1'b1;
        end
        o_push.count = cnt;
        o_push.res   = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_phase   <= SP_MUST_NAK;
            r_pos     <= POS_HEADER;
            r_blknum  <= 8'd0;
            r_sum     <= 8'd0;
            r_expect  <= BLOCK_FIRST;
            r_retries <= RETRY_RESET;
            r_offset  <= '0;
        end else begin
            r_running <= n_running;
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_blknum  <= n_blknum;
            r_sum     <= n_sum;
            r_expect  <= n_expect;
            r_retries <= n_retries;
            r_offset  <= n_offset;
        end
    end

endmodule

### rtl/xcr_queue.sv
// Result queue: a shift line of result registers, head at entry 0.
// Takes up to three results at once; depends on xcr_pkg.
module xcr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  xcr_pkg::t_push   i_push,
    input  logic             i_stall,
    output logic             o_valid,
    output xcr_pkg::t_result o_res,
    output logic             o_full
);
    import xcr_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_result          r_q [QUEUE_DEPTH];
    t_result          n_q [QUEUE_DEPTH];
    logic [CW-1:0]    r_count, n_count;
    logic             pop;
    logic [CW-1:0]    base;

    assign o_valid = (r_count != '0);
    assign o_res   = r_q[0];
    assign pop     = o_valid && !i_stall;
    // room for a full set of results only while at most one is waiting
    assign o_full  = (r_count > CW'(QUEUE_DEPTH - MAX_RESULTS));
    assign base    = r_count - CW'(pop);
    assign n_count = base + CW'(i_push.count);

    always_comb begin
        logic [CW-1:0] k;
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            k = CW'(j) - base;
            if (pop && j < QUEUE_DEPTH - 1) begin
                n_q[j] = r_q[j + 1];
            end else begin
                n_q[j] = r_q[j];
            end
            if (CW'(j) >= base && k < CW'(i_push.count)) begin
                n_q[j] = i_push.res[k[1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            r_q[j] <= n_q[j];
        end
    end

endmodule

### rtl/xmodem_checksum_receiver.sv
// XMODEM checksum receiver, top level.
// Depends on xcr_pkg, xcr_regs, xcr_core and xcr_queue.
//
// Receive side of XMODEM with 128-byte blocks and the 8-bit additive
// checksum. Each request is one event: start a transfer, one received byte,
// or a receive timeout (the timer lives outside). The framing state updates
// at the accepting edge and the up to three results that a request causes
// (ACK/NAK reply bytes, memory writes for data bytes, a finish record with
// status and length) land at once in a four-entry result queue that delivers
// one result per cycle while the output is not stalled. The input stall is
// raised while more than one result waits, so requests that cause one result
// each flow at one per cycle with the output unstalled; a request that causes
// two or three results occupies the output until all are delivered. Data bytes
// are written as they arrive, so a block that is later refused still leaves
// its bytes above the current offset; only the area below the reported length
// is valid. Registers (byte addresses): 0 one_nak_mode (bit 0), 4 retry_limit
// (bits 7:0, reset 20). Write them only while no results are pending.
module xmodem_checksum_receiver (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  xcr_pkg::t_request i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output xcr_pkg::t_result  o_out_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import xcr_pkg::*;

    t_cfg  cfg;
    t_push push;
    logic  accept;
    logic  full;

    // accept a request whenever the queue can hold its worst-case results
    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    xcr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    xcr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_in_req),
        .i_cfg    (cfg),
        .o_push   (push)
    );

    xcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_res   (o_out_res),
        .o_full  (full)
    );

endmodule

### rtl/xcr_checker.sv
// Port-level checks for the XMODEM checksum receiver, bound to the top.
// Depends on xcr_pkg for result codes.
module xcr_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input xcr_pkg::t_result o_out_res
);
    import xcr_pkg::*;

    // queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_res))
        else $error("stalled result changed");

    a_reply_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_res.kind == KIND_REPLY |->
            (o_out_res.tx_byte == CH_ACK || o_out_res.tx_byte == CH_NAK)
            && o_out_res.write_offset == '0 && o_out_res.length == '0)
        else $error("bad reply result");

    a_write_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_res.kind == KIND_WRITE |->
            o_out_res.tx_byte == 8'd0 && o_out_res.status == ST_OK
            && o_out_res.length == '0)
        else $error("memory write carries stray fields");

    a_fail_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_res.kind == KIND_FINISH && o_out_res.status != ST_OK |->
            o_out_res.length == '0 && o_out_res.last)
        else $error("failed finish with length or not last");

endmodule

bind xmodem_checksum_receiver xcr_checker u_xcr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_res   (o_out_res)
);
